// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL, compiled out when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked every clock edge outside reset
`define DTL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Same-cycle implication checked outside reset
`define DTL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`else

`define DTL_ASSERT(lbl, clk, rst, prop)
`define DTL_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/dtl_pkg.sv =====
// Shared types and constants for the dusk lamp sequencer
package dtl_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int STEP_W    = 10;
   localparam int QUARTER_W = 8;
   localparam int LEVEL_W   = 8;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;

   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [STEP_W-1:0]     step_type;
   typedef logic [QUARTER_W-1:0]  quarter_type;
   typedef logic [LEVEL_W-1:0]    level_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Length of the fade ramps in steps
   localparam step_type FADE_STEPS = step_type'(255);
   localparam level_type LEVEL_FULL = '1;

   // Item commands
   localparam logic CMD_STEP   = 1'b0;
   localparam logic CMD_BUTTON = 1'b1;

   // Register indexes
   localparam csr_idx_type CSR_DARK   = 2'd0;
   localparam csr_idx_type CSR_BRIGHT = 2'd1;
   localparam csr_idx_type CSR_LIT    = 2'd2;
   localparam csr_idx_type CSR_TPQ    = 2'd3;

   // Register reset values
   localparam sample_type  DARK_RESET   = sample_type'(150);
   localparam sample_type  BRIGHT_RESET = sample_type'(630);
   localparam quarter_type LIT_RESET    = quarter_type'(1);
   localparam step_type    TPQ_RESET    = step_type'(449);

   typedef enum logic [MODE_W-1:0] {
      MODE_BRIGHT   = 3'd0,
      MODE_FADE_IN  = 3'd1,
      MODE_SETUP    = 3'd2,
      MODE_GLOW     = 3'd3,
      MODE_FADE_OUT = 3'd4,
      MODE_NIGHT    = 3'd5
   } mode_type;

   typedef struct packed {
      sample_type  dark_threshold;
      sample_type  bright_threshold;
      quarter_type lit_quarters;
      step_type    ticks_per_quarter;
   } cfg_type;

   typedef struct packed {
      logic       command;
      sample_type light_sample;
   } item_type;

endpackage

// ===== rtl/dtl_req_if.sv =====
// Input item channel: step tick or button press
interface dtl_req_if;
   import dtl_pkg::*;

   logic       valid;
   logic       ready;
   logic       command;
   sample_type light_sample;

   modport source (output valid, output command, output light_sample, input ready);
   modport sink   (input valid, input command, input light_sample, output ready);
endinterface

// ===== rtl/dtl_rsp_if.sv =====
// Result channel: lamp level and mode
interface dtl_rsp_if;
   import dtl_pkg::*;

   logic      valid;
   logic      ready;
   level_type brightness;
   logic [MODE_W-1:0] mode;

   modport source (output valid, output brightness, output mode, input ready);
   modport sink   (input valid, input brightness, input mode, output ready);
endinterface

// ===== rtl/dtl_csr_if.sv =====
// Register write channel
interface dtl_csr_if;
   import dtl_pkg::*;

   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dtl_csr.sv =====
// Configuration registers with their write decoder
module dtl_csr (
   input  logic            clock,
   input  logic            reset,
   dtl_csr_if.sink         csr_ch,
   output dtl_pkg::cfg_type cfg
);
   import dtl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ch.ready = 1'b1;

   // Index decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DARK:   cfg_in.dark_threshold    = csr_ch.data;
            CSR_BRIGHT: cfg_in.bright_threshold  = csr_ch.data;
            CSR_LIT:    cfg_in.lit_quarters      = csr_ch.data[QUARTER_W-1:0];
            CSR_TPQ:    cfg_in.ticks_per_quarter = csr_ch.data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold    <= DARK_RESET;
         cfg_ff.bright_threshold  <= BRIGHT_RESET;
         cfg_ff.lit_quarters      <= LIT_RESET;
         cfg_ff.ticks_per_quarter <= TPQ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/dtl_seq.sv =====
// Lamp sequencer state: mode, counters and level, updated once per item
module dtl_seq #(
   parameter dtl_pkg::step_type FADE_LEN = dtl_pkg::FADE_STEPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  dtl_pkg::item_type item,
   input  dtl_pkg::cfg_type  cfg,
   output dtl_pkg::level_type level_next,
   output dtl_pkg::mode_type  mode_next
);
   import dtl_pkg::*;

   mode_type    mode_ff, mode_in;
   step_type    step_ff, step_in;
   quarter_type quarter_ff, quarter_in;
   level_type   level_ff, level_in;

   step_type    step_inc;
   quarter_type quarter_inc;
   quarter_type len;
   step_type    tpq;
   logic        is_button;
   logic        fade_done;
   logic        quarter_done;
   logic        glow_done;
   step_type    fade_down;

   // Shared counter arithmetic
   always_comb begin
      is_button    = (item.command == CMD_BUTTON);
      step_inc     = step_ff + step_type'(1);
      quarter_inc  = quarter_ff + quarter_type'(1);
      len          = (cfg.lit_quarters == '0) ? quarter_type'(1) : cfg.lit_quarters;
      tpq          = (cfg.ticks_per_quarter == '0) ? step_type'(1)
                                                    : cfg.ticks_per_quarter;
      fade_done    = (step_inc >= FADE_LEN);
      quarter_done = (step_inc >= tpq);
      glow_done    = quarter_done && (quarter_inc >= len);
      fade_down    = FADE_LEN - step_ff;
   end

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      if (is_button) begin
         mode_in = (mode_ff == MODE_GLOW) ? MODE_NIGHT : MODE_SETUP;
      end else begin
         unique case (mode_ff)
            MODE_BRIGHT:   if (item.light_sample <= cfg.dark_threshold) mode_in = MODE_FADE_IN;
            MODE_FADE_IN:  if (fade_done) mode_in = MODE_SETUP;
            MODE_SETUP:    mode_in = MODE_GLOW;
            MODE_GLOW:     if (glow_done) mode_in = MODE_FADE_OUT;
            MODE_FADE_OUT: if (fade_done) mode_in = MODE_NIGHT;
            MODE_NIGHT: begin
               if (item.light_sample >= cfg.bright_threshold) mode_in = MODE_BRIGHT;
            end
            default:       mode_in = MODE_BRIGHT;
         endcase
      end
   end

   // Counters and lamp level
   always_comb begin
      step_in    = step_ff;
      quarter_in = quarter_ff;
      level_in   = level_ff;
      if (is_button) begin
         if (mode_ff == MODE_GLOW) level_in = '0;
      end else begin
         unique case (mode_ff)
            MODE_BRIGHT: begin
               if (item.light_sample <= cfg.dark_threshold) step_in = step_type'(1);
            end
            MODE_FADE_IN: begin
               level_in = step_ff[LEVEL_W-1:0];
               step_in  = step_inc;
            end
            MODE_SETUP: begin
               level_in   = LEVEL_FULL;
               quarter_in = '0;
               step_in    = '0;
            end
            MODE_GLOW: begin
               step_in = step_inc;
               if (quarter_done) begin
                  quarter_in = quarter_inc;
                  step_in    = glow_done ? step_type'(1) : '0;
               end
            end
            MODE_FADE_OUT: begin
               // Ramp down; the last step lands on off
               level_in = (step_ff >= FADE_LEN) ? '0 : fade_down[LEVEL_W-1:0];
               step_in  = step_inc;
               if (fade_done) level_in = '0;
            end
            MODE_NIGHT: begin
               level_in = level_ff;
            end
            default: begin
               level_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_BRIGHT;
         step_ff    <= '0;
         quarter_ff <= '0;
         level_ff   <= '0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         step_ff    <= step_in;
         quarter_ff <= quarter_in;
         level_ff   <= level_in;
      end
   end

   assign level_next = level_in;
   assign mode_next  = mode_in;

endmodule

// ===== rtl/dusk_timer_light_fsm.sv =====
// Dusk lamp sequencer top level: input register, sequencer, result register.
// An accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle while the result channel is not stalled; the sequencer update is a single short pass.
// Reset (synchronous, active high) puts the lamp off in bright mode, clears
// both counters, empties both registers and restores the register defaults.
`include "assert_macros.svh"

module dusk_timer_light_fsm #(
   parameter dtl_pkg::step_type FADE_LEN = dtl_pkg::FADE_STEPS
) (
   input  logic      clock,
   input  logic      reset,
   dtl_req_if.sink   req_ch,
   dtl_rsp_if.source rsp_ch,
   dtl_csr_if.sink   csr_ch
);
   import dtl_pkg::*;

   cfg_type   cfg;
   item_type  item_ff;
   logic      item_valid_ff;
   logic      advance;
   level_type level_next;
   mode_type  mode_next;
   logic      rsp_valid_ff;
   level_type rsp_level_ff;
   mode_type  rsp_mode_ff;
   logic      rsp_glow;
   logic      rsp_dark;

   dtl_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Input register moves on when the result register is free or being drained
   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         item_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.command      <= req_ch.command;
         item_ff.light_sample <= req_ch.light_sample;
      end
   end

   dtl_seq #(
      .FADE_LEN (FADE_LEN)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item_ff),
      .cfg        (cfg),
      .level_next (level_next),
      .mode_next  (mode_next)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_level_ff <= level_next;
         rsp_mode_ff  <= mode_next;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.brightness = rsp_level_ff;
   assign rsp_ch.mode       = rsp_mode_ff;

   // Held result modes that fix the lamp level
   assign rsp_glow = rsp_valid_ff && (rsp_mode_ff == MODE_GLOW);
   assign rsp_dark = rsp_valid_ff && (rsp_mode_ff == MODE_NIGHT || rsp_mode_ff == MODE_BRIGHT);

   // Glow always shows a full lamp; night and bright always show it off
   `DTL_ASSERT_IMPL(a_glow_full, clock, reset, rsp_glow, rsp_level_ff == LEVEL_FULL)
   `DTL_ASSERT_IMPL(a_dark_off, clock, reset, rsp_dark, rsp_level_ff == '0)
   // A new result only follows a held item
   `DTL_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(item_valid_ff))

endmodule
